>>> hw/rtl/cosc_pkg.sv
// Package for the coin-op session controller.
// Mode and action codes, widths, reset defaults and the result layout.
// No dependencies.
`timescale 1ns / 1ps

package cosc_pkg;

    localparam int unsigned TIMER_W  = 32;
    localparam int unsigned CREDIT_W = 31;
    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 72;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [TIMER_W-1:0]  TIMEOUT_DEFAULT     = 32'd30000;
    localparam logic [TIMER_W-1:0]  PAUSE_LIMIT_DEFAULT = 32'd60000;
    localparam logic [TIMER_W-1:0]  TIMER_MAX           = '1;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX          = '1;

    // paddr[2] selects the register index
    localparam logic REG_TIMEOUT = 1'b0;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CREDIT  = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_PAUSED  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_ACTIVITY = 3'd1,
        ACT_PAYMENT  = 3'd2,
        ACT_SELECT   = 3'd3,
        ACT_STOP     = 3'd4,
        ACT_PAUSE    = 3'd5,
        ACT_CRED_END = 3'd6,
        ACT_NONE     = 3'd7
    } action_t;

    // declared MSB first: changed lands in bit 0
    typedef struct packed {
        logic [CREDIT_W-1:0] charged_price;
        logic                run_completed;
        logic                insufficient;
        logic                pause_expired;
        logic                running;
        logic [CREDIT_W-1:0] credit;
        mode_t               mode;
        logic                changed;
    } result_t;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [TIMER_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

>>> hw/rtl/coin_op_session_controller.sv
// Coin-op session controller top level: session state, item decode, result register.
// Depends on cosc_pkg.
//
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tuser action, s_tdata timer/price fields
// m_       | out | m_tvalid/m_tready  | m_tdata session result
// apb      | in  | psel/penable       | inactivity timeout register
//
// One request per cycle while s_tready is high; its result shows on m_ in the cycle after acceptance.
// The session state and the result register update in the same cycle.
// aresetn is synchronous, active low; clears state and the result valid.
// s_tready drops only while a result is held and m_tready is low.
`timescale 1ns / 1ps

module coin_op_session_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] amount, [63:32] pause_limit_ms, [95:64] run_target_ms, [127:96] tick_delta_ms
    input  logic [cosc_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] action
    input  logic [cosc_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] changed, [2:1] mode, [33:3] credit, [34] running, [35] pause_expired,
    // [36] insufficient, [37] run_completed, [68:38] charged_price, [71:69] zero
    output logic [cosc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cosc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int unsigned TW = cosc_pkg::TIMER_W;
    localparam int unsigned CW = cosc_pkg::CREDIT_W;

    logic [TW-1:0]     timeout_reg;
    cosc_pkg::mode_t   mode_reg, mode_next;
    logic [CW-1:0]     credit_reg, credit_next;
    logic              active_reg, active_next;
    logic [TW-1:0]     run_elapsed_reg, run_elapsed_next;
    logic [TW-1:0]     pause_elapsed_reg, pause_elapsed_next;
    logic [TW-1:0]     pause_limit_reg, pause_limit_next;
    logic              reached_reg, reached_next;
    logic [TW-1:0]     run_target_reg, run_target_next;
    logic [CW-1:0]     run_price_reg, run_price_next;
    logic [TW-1:0]     inact_reg, inact_next;
    logic              m_valid_reg;
    cosc_pkg::result_t res_reg, res_next;

    cosc_pkg::action_t action;
    logic [TW-1:0]     amount, plim, rtgt, elapsed;
    logic              amt_pos;
    logic [TW-1:0]     inact_sum, run_sum, pause_sum;
    logic [TW-1:0]     pay_sum;
    logic [CW-1:0]     price;
    logic [CW-1:0]     credit_left;
    logic              insufficient, completed;
    logic [CW-1:0]     charged;
    logic              s_accept, cfg_write;

    assign action   = cosc_pkg::action_t'(s_tuser);
    assign amount   = s_tdata[31:0];
    assign plim     = s_tdata[63:32];
    assign rtgt     = s_tdata[95:64];
    assign elapsed  = s_tdata[127:96];
    assign amt_pos  = (amount != '0) && !amount[TW-1];
    assign price    = amt_pos ? amount[CW-1:0] : '0;

    assign inact_sum = cosc_pkg::sat_add(inact_reg, elapsed);
    assign run_sum   = cosc_pkg::sat_add(run_elapsed_reg, elapsed);
    assign pause_sum = cosc_pkg::sat_add(pause_elapsed_reg, elapsed);
    assign pay_sum   = {1'b0, credit_reg} + {1'b0, price};
    assign credit_left = credit_reg - price;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == cosc_pkg::REG_TIMEOUT) ? timeout_reg : '0;

    always_comb begin
        mode_next          = mode_reg;
        credit_next        = credit_reg;
        active_next        = active_reg;
        run_elapsed_next   = run_elapsed_reg;
        pause_elapsed_next = pause_elapsed_reg;
        pause_limit_next   = pause_limit_reg;
        reached_next       = reached_reg;
        run_target_next    = run_target_reg;
        run_price_next     = run_price_reg;
        inact_next         = inact_reg;
        insufficient       = 1'b0;
        completed          = 1'b0;
        charged            = '0;

        case (action)
            cosc_pkg::ACT_TICK: begin
                inact_next = inact_sum;
                if (mode_reg == cosc_pkg::MODE_RUNNING) begin
                    run_elapsed_next = run_sum;
                    if (run_target_reg != '0 && run_sum >= run_target_reg) begin
                        completed = 1'b1;
                        charged   = run_price_reg;
                    end
                end else if (mode_reg == cosc_pkg::MODE_PAUSED && !reached_reg) begin
                    pause_elapsed_next = pause_sum;
                    reached_next       = pause_sum >= pause_limit_reg;
                end
                if (completed || (mode_reg == cosc_pkg::MODE_CREDIT &&
                                  inact_sum >= timeout_reg)) begin
                    mode_next          = completed ? cosc_pkg::MODE_CREDIT
                                                   : cosc_pkg::MODE_IDLE;
                    if (!completed)
                        credit_next = '0;
                    active_next        = 1'b0;
                    run_elapsed_next   = '0;
                    pause_elapsed_next = '0;
                    reached_next       = 1'b0;
                    inact_next         = '0;
                    run_target_next    = '0;
                    run_price_next     = '0;
                end
            end
            cosc_pkg::ACT_ACTIVITY, cosc_pkg::ACT_PAYMENT: begin
                if (action == cosc_pkg::ACT_PAYMENT && amt_pos)
                    credit_next = pay_sum[TW-1] ? cosc_pkg::CREDIT_MAX : pay_sum[CW-1:0];
                if (mode_reg == cosc_pkg::MODE_IDLE) begin
                    mode_next          = cosc_pkg::MODE_CREDIT;
                    run_elapsed_next   = '0;
                    pause_elapsed_next = '0;
                    reached_next       = 1'b0;
                    inact_next         = '0;
                end else if (mode_reg == cosc_pkg::MODE_CREDIT &&
                             action == cosc_pkg::ACT_PAYMENT) begin
                    inact_next = '0;
                end
            end
            cosc_pkg::ACT_SELECT: begin
                if (mode_reg == cosc_pkg::MODE_CREDIT) begin
                    if (plim != '0)
                        pause_limit_next = plim;
                    if (rtgt != '0)
                        run_target_next = rtgt;
                    run_price_next = price;
                    if (credit_reg < price) begin
                        insufficient = 1'b1;
                    end else begin
                        credit_next = credit_left;
                        if (credit_left != '0) begin
                            mode_next          = cosc_pkg::MODE_RUNNING;
                            active_next        = 1'b1;
                            run_elapsed_next   = '0;
                            pause_elapsed_next = '0;
                            reached_next       = 1'b0;
                            inact_next         = '0;
                        end
                    end
                end
            end
            cosc_pkg::ACT_STOP, cosc_pkg::ACT_CRED_END: begin
                if (action == cosc_pkg::ACT_CRED_END)
                    credit_next = '0;
                if (mode_reg == cosc_pkg::MODE_RUNNING || mode_reg == cosc_pkg::MODE_PAUSED) begin
                    mode_next          = cosc_pkg::MODE_CREDIT;
                    active_next        = 1'b0;
                    run_elapsed_next   = '0;
                    pause_elapsed_next = '0;
                    reached_next       = 1'b0;
                    inact_next         = '0;
                    run_target_next    = '0;
                    run_price_next     = '0;
                end
            end
            cosc_pkg::ACT_PAUSE: begin
                if (mode_reg == cosc_pkg::MODE_RUNNING || mode_reg == cosc_pkg::MODE_PAUSED) begin
                    mode_next          = (mode_reg == cosc_pkg::MODE_RUNNING)
                                         ? cosc_pkg::MODE_PAUSED : cosc_pkg::MODE_RUNNING;
                    active_next        = (mode_reg == cosc_pkg::MODE_PAUSED);
                    pause_elapsed_next = '0;
                    reached_next       = 1'b0;
                    inact_next         = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res_next.changed       = (mode_next != mode_reg);
        res_next.mode          = mode_next;
        res_next.credit        = credit_next;
        res_next.running       = active_next;
        res_next.pause_expired = reached_next;
        res_next.insufficient  = insufficient;
        res_next.run_completed = completed;
        res_next.charged_price = charged;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg       <= cosc_pkg::TIMEOUT_DEFAULT;
            mode_reg          <= cosc_pkg::MODE_IDLE;
            credit_reg        <= '0;
            active_reg        <= 1'b0;
            run_elapsed_reg   <= '0;
            pause_elapsed_reg <= '0;
            pause_limit_reg   <= cosc_pkg::PAUSE_LIMIT_DEFAULT;
            reached_reg       <= 1'b0;
            run_target_reg    <= '0;
            run_price_reg     <= '0;
            inact_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_write && paddr[2] == cosc_pkg::REG_TIMEOUT)
                timeout_reg <= pwdata;
            if (s_accept) begin
                mode_reg          <= mode_next;
                credit_reg        <= credit_next;
                active_reg        <= active_next;
                run_elapsed_reg   <= run_elapsed_next;
                pause_elapsed_reg <= pause_elapsed_next;
                pause_limit_reg   <= pause_limit_next;
                reached_reg       <= reached_next;
                run_target_reg    <= run_target_next;
                run_price_reg     <= run_price_next;
                inact_reg         <= inact_next;
                m_valid_reg       <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept)
            res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(cosc_pkg::M_DATA_W - $bits(cosc_pkg::result_t)){1'b0}}, res_reg};

    a_active_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (mode_reg == cosc_pkg::MODE_RUNNING))
        else $error("program flag out of step with mode");

    a_reached_paused: assert property (@(posedge aclk) disable iff (!aresetn)
        reached_reg |-> mode_reg == cosc_pkg::MODE_PAUSED)
        else $error("pause flag set outside paused mode");

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted request produced no result");

    a_completed_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.run_completed) |->
            (res_reg.mode == cosc_pkg::MODE_CREDIT && res_reg.changed))
        else $error("completed run did not return to credit");

    a_refused_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.insufficient) |-> !res_reg.changed)
        else $error("refused select changed mode");

endmodule

>>> verif/coin_op_session_controller_tb.sv
// Self-checking testbench for coin_op_session_controller: directed table then mode-aware
// random requests, results checked field by field vs. table rows or an in-bench predictor.
// Depends on cosc_pkg and the coin_op_session_controller RTL.
`timescale 1ns / 1ps

module coin_op_session_controller_tb;

    import cosc_pkg::*;

    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned PHASE_ITEMS = 400;
    localparam logic [PADDR_W-1:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};

    typedef struct packed {
        action_t     act;
        logic [31:0] amount;
        logic [31:0] plim;
        logic [31:0] rtgt;
        logic [31:0] elapsed;
    } sess_req_t;

    typedef struct packed {
        sess_req_t rq;
        logic      has_exp;
        result_t   exp;
    } dir_row_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predicted session state
    mode_t         p_mode;
    logic [30:0]   p_credit;
    logic          p_active;
    logic [31:0]   p_run_el;
    logic [31:0]   p_pause_el;
    logic [31:0]   p_pause_lim;
    logic          p_pause_hit;
    logic [31:0]   p_run_tgt;
    logic [30:0]   p_price;
    logic [31:0]   p_inact;
    logic [31:0]   p_timeout;

    result_t       session_results_due[$];
    dir_row_t      dir_rows[$];
    int unsigned   err_cnt      = 0;
    int unsigned   items_sent   = 0;
    int unsigned   results_seen = 0;
    int unsigned   runs_done    = 0;
    int unsigned   refusals     = 0;
    int unsigned   idle_drops   = 0;
    int unsigned   cycle_cnt    = 0;
    int unsigned   stall_left   = 0;

    coin_op_session_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_cnt, session_results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- session predictor ----------------

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_timers();
        p_run_el    = '0;
        p_pause_el  = '0;
        p_pause_hit = 1'b0;
        p_inact     = '0;
    endfunction

    function automatic void end_program();
        p_active  = 1'b0;
        clear_timers();
        p_run_tgt = '0;
        p_price   = '0;
    endfunction

    function automatic void stop_session();
        if (p_mode == MODE_RUNNING || p_mode == MODE_PAUSED) begin
            p_mode = MODE_CREDIT;
            end_program();
        end
    endfunction

    function automatic void reset_session_model();
        p_timeout   = TIMEOUT_DEFAULT;
        p_mode      = MODE_IDLE;
        p_credit    = '0;
        p_pause_lim = PAUSE_LIMIT_DEFAULT;
        end_program();
    endfunction

    function automatic result_t predict_session(input sess_req_t rq);
        result_t     r;
        mode_t       prev;
        logic        amt_pos;
        logic [31:0] csum;
        r       = '0;
        prev    = p_mode;
        amt_pos = (rq.amount != 0) && !rq.amount[31];
        case (rq.act)
            ACT_TICK: begin
                p_inact = add_clamped(p_inact, rq.elapsed);
                if (p_mode == MODE_RUNNING) begin
                    p_run_el = add_clamped(p_run_el, rq.elapsed);
                    if (p_run_tgt != 0 && p_run_el >= p_run_tgt) begin
                        r.run_completed = 1'b1;
                        r.charged_price = p_price;
                        stop_session();
                        runs_done++;
                    end
                end else if (p_mode == MODE_PAUSED && !p_pause_hit) begin
                    p_pause_el = add_clamped(p_pause_el, rq.elapsed);
                    if (p_pause_el >= p_pause_lim) p_pause_hit = 1'b1;
                end
                // a completing tick skips the inactivity check
                if (!r.run_completed && p_mode == MODE_CREDIT && p_inact >= p_timeout) begin
                    p_mode   = MODE_IDLE;
                    p_credit = '0;
                    end_program();
                    idle_drops++;
                end
            end
            ACT_ACTIVITY, ACT_PAYMENT: begin
                if (rq.act == ACT_PAYMENT && amt_pos) begin
                    csum     = {1'b0, p_credit} + rq.amount;
                    p_credit = (csum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : csum[30:0];
                end
                if (p_mode == MODE_IDLE) begin
                    p_mode = MODE_CREDIT;
                    clear_timers();
                end else if (p_mode == MODE_CREDIT && rq.act == ACT_PAYMENT) begin
                    p_inact = '0;
                end
            end
            ACT_SELECT: begin
                if (p_mode == MODE_CREDIT) begin
                    if (rq.plim != 0) p_pause_lim = rq.plim;
                    if (rq.rtgt != 0) p_run_tgt = rq.rtgt;
                    p_price = amt_pos ? rq.amount[30:0] : '0;
                    if (p_price != 0 && p_credit < p_price) begin
                        r.insufficient = 1'b1;
                        refusals++;
                    end else begin
                        p_credit = p_credit - p_price;
                        if (p_credit != 0) begin
                            p_mode   = MODE_RUNNING;
                            p_active = 1'b1;
                            clear_timers();
                        end
                    end
                end
            end
            ACT_STOP: stop_session();
            ACT_PAUSE: begin
                if (p_mode == MODE_RUNNING || p_mode == MODE_PAUSED) begin
                    p_mode      = (p_mode == MODE_RUNNING) ? MODE_PAUSED : MODE_RUNNING;
                    p_active    = (p_mode == MODE_RUNNING);
                    p_pause_el  = '0;
                    p_pause_hit = 1'b0;
                    p_inact     = '0;
                end
            end
            ACT_CRED_END: begin
                p_credit = '0;
                stop_session();
            end
            default: ;
        endcase
        r.changed       = (prev != p_mode);
        r.mode          = p_mode;
        r.credit        = p_credit;
        r.running       = p_active;
        r.pause_expired = p_pause_hit;
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic result_t typed_result(input logic chg, input mode_t md,
                                             input logic [30:0] cr, input logic run,
                                             input logic pe, input logic ins,
                                             input logic rc, input logic [30:0] cp);
        result_t r;
        r.changed       = chg;
        r.mode          = md;
        r.credit        = cr;
        r.running       = run;
        r.pause_expired = pe;
        r.insufficient  = ins;
        r.run_completed = rc;
        r.charged_price = cp;
        return r;
    endfunction

    function automatic void add_row(input action_t act, input logic [31:0] amt,
                                    input logic [31:0] plim, input logic [31:0] rtgt,
                                    input logic [31:0] el, input logic has_exp,
                                    input result_t exp);
        dir_row_t row;
        row.rq.act     = act;
        row.rq.amount  = amt;
        row.rq.plim    = plim;
        row.rq.rtgt    = rtgt;
        row.rq.elapsed = el;
        row.has_exp    = has_exp;
        row.exp        = exp;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [31:0] draw_elapsed();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) return 32'hFFFF_FFFF;
        if (pick < 9) return $urandom;
        if (pick < 14) return '0;
        return $urandom_range(1, 900);
    endfunction

    function automatic logic [31:0] draw_setting(input int unsigned lo, input int unsigned hi);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 15) return $urandom;
        if (pick < 18) return 32'hFFFF_FFFF;
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [31:0] draw_amount();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return 32'hFFFF_FFFF;
        if (pick < 6) return 32'h8000_0000;
        if (pick < 9) return 32'h7FFF_FFFF;
        if (pick < 14) return $urandom;
        if (pick < 18) return '0;
        return $urandom_range(1, 400);
    endfunction

    // mostly requests that make sense in the current mode, some noise
    function automatic sess_req_t draw_request();
        sess_req_t   r;
        int unsigned pick;
        int unsigned sub;
        r.amount  = draw_amount();
        r.plim    = draw_setting(50, 3000);
        r.rtgt    = draw_setting(100, 4000);
        r.elapsed = draw_elapsed();
        pick      = $urandom_range(0, 99);
        if (pick < 12) begin
            r.act = action_t'($urandom_range(0, 7));
            return r;
        end
        case (p_mode)
            MODE_IDLE: begin
                if (pick < 50)      r.act = ACT_PAYMENT;
                else if (pick < 80) r.act = ACT_ACTIVITY;
                else                r.act = ACT_TICK;
            end
            MODE_CREDIT: begin
                if (pick < 40)      r.act = ACT_TICK;
                else if (pick < 60) r.act = ACT_PAYMENT;
                else if (pick < 90) begin
                    r.act = ACT_SELECT;
                    sub   = $urandom_range(0, 9);
                    if (sub == 0)      r.amount = {1'b0, p_credit};
                    else if (sub == 1) r.amount = {1'b0, p_credit} + 1;
                    else if (sub > 2)
                        r.amount = $urandom_range(1, (p_credit > 1) ? p_credit / 2 : 1);
                end
                else                r.act = ACT_ACTIVITY;
            end
            MODE_RUNNING: begin
                if (pick < 70)      r.act = ACT_TICK;
                else if (pick < 80) r.act = ACT_PAUSE;
                else if (pick < 88) r.act = ACT_STOP;
                else if (pick < 93) r.act = ACT_CRED_END;
                else                r.act = ACT_PAYMENT;
            end
            default: begin
                if (pick < 70)      r.act = ACT_TICK;
                else if (pick < 88) r.act = ACT_PAUSE;
                else if (pick < 94) r.act = ACT_STOP;
                else                r.act = ACT_CRED_END;
            end
        endcase
        return r;
    endfunction

    task automatic send_req(input sess_req_t rq, input logic has_exp, input result_t exp);
        int unsigned gap;
        result_t     pred;
        gap = ((items_sent / 64) % 4 == 1) ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.act;
        s_tdata  <= {rq.elapsed, rq.rtgt, rq.plim, rq.amount};
        do @(posedge aclk); while (!s_tready);
        pred = predict_session(rq);
        session_results_due.push_back(has_exp ? exp : pred);
        items_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) send_req(draw_request(), 1'b0, '0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (session_results_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_timeout(input logic [31:0] value, input logic do_write);
        logic [31:0] rd;
        if (do_write) begin
            apb_access(1'b1, value, rd);
            p_timeout = value;
        end
        apb_access(1'b0, '0, rd);
        if (rd !== value) begin
            $display("%0t: timeout register expected %0h got %0h", $time, value, rd);
            err_cnt++;
        end
    endtask

    // ---------------- result side ----------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin : result_sink
        result_t     got;
        result_t     want;
        int unsigned stall;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (m_tvalid && m_tready) begin
            got = result_t'(m_tdata[68:0]);
            if (session_results_due.size() == 0) begin
                $display("%0t: unexpected result %0h", $time, m_tdata);
                err_cnt++;
            end else begin
                want = session_results_due.pop_front();
                compare_field("changed", want.changed, got.changed);
                compare_field("mode", want.mode, got.mode);
                compare_field("credit", want.credit, got.credit);
                compare_field("running", want.running, got.running);
                compare_field("pause_expired", want.pause_expired, got.pause_expired);
                compare_field("insufficient", want.insufficient, got.insufficient);
                compare_field("run_completed", want.run_completed, got.run_completed);
                compare_field("charged_price", want.charged_price, got.charged_price);
                compare_field("pad", '0, m_tdata[M_DATA_W-1:69]);
            end
            results_seen++;
            // long hold-off lets the result register fill and back up the input
            if (results_seen % 400 == 200)        stall = 150;
            else if ((results_seen / 64) % 4 == 3) stall = 0;
            else                                   stall = $urandom_range(0, 9);
            stall_left = stall;
            m_tready <= (stall == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        logic [31:0] phase_timeout[3];
        phase_timeout[0] = '0;
        phase_timeout[1] = 32'hFFFF_FFFF;
        phase_timeout[2] = $urandom_range(500, 5000);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reset_session_model();
        program_timeout(TIMEOUT_DEFAULT, 1'b0);

        add_row(ACT_TICK, 0, 0, 0, 0, 1'b1,
                typed_result(0, MODE_IDLE, 0, 0, 0, 0, 0, 0));
        add_row(ACT_ACTIVITY, 0, 0, 0, 0, 1'b1,
                typed_result(1, MODE_CREDIT, 0, 0, 0, 0, 0, 0));
        add_row(ACT_PAYMENT, 32'h8000_0000, 0, 0, 0, 1'b1,
                typed_result(0, MODE_CREDIT, 0, 0, 0, 0, 0, 0));
        add_row(ACT_PAYMENT, 0, 0, 0, 0, 1'b1,
                typed_result(0, MODE_CREDIT, 0, 0, 0, 0, 0, 0));
        add_row(ACT_PAYMENT, 32'h7FFF_FFFF, 0, 0, 0, 1'b1,
                typed_result(0, MODE_CREDIT, CREDIT_MAX, 0, 0, 0, 0, 0));
        add_row(ACT_PAYMENT, 1, 0, 0, 0, 1'b1,
                typed_result(0, MODE_CREDIT, CREDIT_MAX, 0, 0, 0, 0, 0));
        add_row(ACT_CRED_END, 0, 0, 0, 0, 1'b1,
                typed_result(0, MODE_CREDIT, 0, 0, 0, 0, 0, 0));
        add_row(ACT_SELECT, 50, 0, 1000, 0, 1'b1,
                typed_result(0, MODE_CREDIT, 0, 0, 0, 1, 0, 0));
        add_row(ACT_PAYMENT, 50, 0, 0, 0, 1'b0, '0);
        add_row(ACT_SELECT, 50, 0, 0, 0, 1'b0, '0);           // spends all credit
        add_row(ACT_PAYMENT, 200, 0, 0, 0, 1'b0, '0);
        add_row(ACT_SELECT, 50, 100, 1000, 0, 1'b0, '0);
        add_row(ACT_TICK, 0, 0, 0, 400, 1'b0, '0);
        add_row(ACT_PAUSE, 0, 0, 0, 0, 1'b0, '0);
        add_row(ACT_TICK, 0, 0, 0, 100, 1'b0, '0);            // pause limit hit
        add_row(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(ACT_PAYMENT, 10, 0, 0, 0, 1'b0, '0);
        add_row(ACT_PAUSE, 0, 0, 0, 0, 1'b0, '0);
        add_row(ACT_TICK, 0, 0, 0, 600, 1'b0, '0);            // run completes
        add_row(ACT_STOP, 0, 0, 0, 0, 1'b0, '0);
        add_row(ACT_NONE, '1, '1, '1, '1, 1'b0, '0);
        add_row(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0);  // inactivity to idle
        add_row(ACT_SELECT, 5, 0, 0, 0, 1'b0, '0);
        add_row(ACT_PAYMENT, 7, 0, 0, 0, 1'b0, '0);
        add_row(ACT_SELECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b0, '0);
        add_row(ACT_TICK, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0);  // no target, keeps running
        add_row(ACT_PAUSE, 0, 0, 0, 0, 1'b0, '0);
        add_row(ACT_STOP, 0, 0, 0, 0, 1'b0, '0);

        foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].has_exp, dir_rows[i].exp);
        send_random(PHASE_ITEMS);

        for (int p = 0; p < 3; p++) begin
            drain();
            program_timeout(phase_timeout[p], 1'b1);
            send_random(PHASE_ITEMS);
        end
        drain();
        repeat (5) @(posedge aclk);

        $display("Sent %0d requests over 4 timeout settings, checked %0d results.",
                 items_sent, results_seen);
        $display("Seen: %0d completed runs, %0d refused selects, %0d inactivity drops.",
                 runs_done, refusals, idle_drops);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
